// ===== rtl/rfc_pkg.sv =====
// Shared types, constants and the CRC byte function of the response frame checker.
`timescale 1ns / 1ps

package rfc_pkg;

  localparam int unsigned MAX_FRAME_DEF = 255;
  localparam int unsigned CFG_IDX_W     = 8;

  localparam logic [7:0] HDR_LEN    = 8'd11;
  localparam logic [7:0] CMD_POS    = 8'd11;
  localparam logic [7:0] LEN_POS    = 8'd15;
  localparam logic [7:0] BODY_START = 8'd16;
  localparam logic [7:0] MIN_BODY   = 8'd8;
  localparam logic [8:0] CRC_END    = 9'd7;

  localparam logic [7:0]  SYNC_HI     = 8'h55;
  localparam logic [7:0]  SYNC_LO     = 8'hAA;
  localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
  localparam logic [31:0] SUFFIX_WORD = 32'h0000_AA55;

  localparam logic [7:0] CMD_CODE_RST   = 8'h07;
  localparam logic [7:0] MIN_LENGTH_RST = 8'd12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COMMAND_CODE = 8'd0,
    REG_MIN_LENGTH   = 8'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DATA_ERR = 2'd1,
    ST_SIZE_ERR = 2'd2,
    ST_CRC_ERR  = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_req_t;

  function automatic logic [7:0] hdr_byte(input logic [3:0] pos);
    logic [7:0] val;
    unique case (pos)
      4'd2:    val = SYNC_HI;
      4'd3:    val = SYNC_LO;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] crc;
    crc = crc_in ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
    end
    return crc;
  endfunction

endpackage

// ===== rtl/rfc_frame.sv =====
// Per-frame state of the checker: field checks, running CRC, tail window and status.
`timescale 1ns / 1ps

module rfc_frame #(
  parameter int unsigned MAX_FRAME = rfc_pkg::MAX_FRAME_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  rfc_pkg::byte_req_t req_i,
  input  logic [7:0]         command_code_i,
  input  logic [7:0]         min_length_i,
  output rfc_pkg::status_e   status_o
);

  localparam logic [7:0] MaxCount = 8'(MAX_FRAME);

  logic [7:0]  count_q, count_d;
  logic [7:0]  len_q, len_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] hist_q, hist_d;
  logic [63:0] tail_q, tail_d;
  logic        hdr_bad_q, hdr_bad_d;
  logic        body_bad_q, body_bad_d;
  logic        too_long;
  logic        hdr_miss;
  logic [8:0]  crc_last;

  assign too_long = count_q >= MaxCount;
  assign len_d    = (!too_long && count_q == rfc_pkg::LEN_POS) ? req_i.data : len_q;
  assign crc_last = {1'b0, len_d} + rfc_pkg::CRC_END;

  always_comb begin
    hdr_miss = 1'b0;
    if (count_q < rfc_pkg::HDR_LEN) begin
      hdr_miss = req_i.data != rfc_pkg::hdr_byte(count_q[3:0]);
    end else if (count_q == rfc_pkg::CMD_POS) begin
      hdr_miss = req_i.data != command_code_i;
    end else if (count_q < rfc_pkg::LEN_POS) begin
      hdr_miss = req_i.data != 8'h00;
    end
  end

  always_comb begin
    count_d    = count_q;
    crc_d      = crc_q;
    hist_d     = hist_q;
    tail_d     = tail_q;
    hdr_bad_d  = hdr_bad_q;
    body_bad_d = body_bad_q;
    if (!too_long) begin
      count_d   = count_q + 8'd1;
      crc_d     = rfc_pkg::crc_byte(crc_q, req_i.data);
      tail_d    = {tail_q[55:0], req_i.data};
      hdr_bad_d = hdr_bad_q | hdr_miss;
      if (count_q >= rfc_pkg::BODY_START && {1'b0, count_q} <= crc_last &&
          req_i.data != 8'h00) begin
        body_bad_d = 1'b1;
      end
      if (count_q >= rfc_pkg::LEN_POS && {1'b0, count_q} == crc_last) begin
        hist_d = ~crc_d;
      end
    end
  end

  always_comb begin
    if (hdr_bad_d) begin
      status_o = rfc_pkg::ST_DATA_ERR;
    end else if (too_long || count_d < rfc_pkg::BODY_START ||
                 (count_d - rfc_pkg::BODY_START) != len_d ||
                 len_d < min_length_i || len_d < rfc_pkg::MIN_BODY) begin
      status_o = rfc_pkg::ST_SIZE_ERR;
    end else if (body_bad_d) begin
      status_o = rfc_pkg::ST_DATA_ERR;
    end else if (tail_d[63:32] != hist_d) begin
      status_o = rfc_pkg::ST_CRC_ERR;
    end else if (tail_d[31:0] != rfc_pkg::SUFFIX_WORD) begin
      status_o = rfc_pkg::ST_DATA_ERR;
    end else begin
      status_o = rfc_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      len_q      <= '0;
      crc_q      <= rfc_pkg::CRC_INIT;
      hist_q     <= '0;
      tail_q     <= '0;
      hdr_bad_q  <= 1'b0;
      body_bad_q <= 1'b0;
    end else if (step_i) begin
      if (req_i.last) begin
        count_q    <= '0;
        len_q      <= '0;
        crc_q      <= rfc_pkg::CRC_INIT;
        hist_q     <= '0;
        tail_q     <= '0;
        hdr_bad_q  <= 1'b0;
        body_bad_q <= 1'b0;
      end else begin
        count_q    <= count_d;
        len_q      <= len_d;
        crc_q      <= crc_d;
        hist_q     <= hist_d;
        tail_q     <= tail_d;
        hdr_bad_q  <= hdr_bad_d;
        body_bad_q <= body_bad_d;
      end
    end
  end

endmodule

// ===== rtl/response_frame_checker.sv =====
// Top level of the response frame checker: request register, frame logic and result register.
`timescale 1ns / 1ps

// Checks a response frame that arrives one byte per request and returns one status
// after the byte flagged as last (0 ok, 1 data error, 2 size error, 3 crc error).
// One byte is taken every cycle unless input is held; the running CRC-32 advances a full byte
// combinationally between the request register and the result register, which sets this rate.
// A final byte's status is registered once it leaves the request register. Input is held only
// while a finished status waits at the output and another final byte is ready to leave.
// Registers: index 0 sets the command code byte, index 1 the minimum length; other
// indexes are ignored. Write them only while no frame is in flight.
module response_frame_checker #(
  parameter int unsigned MAX_FRAME = rfc_pkg::MAX_FRAME_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    data_byte_i,
  input  logic                          last_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rfc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]                    cfg_data_i
);

  logic               s1_valid_q, s1_valid_d;
  rfc_pkg::byte_req_t s1_req_q;
  logic               s1_fire;
  logic               out_free;
  logic               out_valid_q, out_valid_d;
  rfc_pkg::status_e   status_q;
  rfc_pkg::status_e   frame_status;
  logic [7:0]         cmd_code_q;
  logic [7:0]         min_len_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_code_q <= rfc_pkg::CMD_CODE_RST;
      min_len_q  <= rfc_pkg::MIN_LENGTH_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == rfc_pkg::REG_COMMAND_CODE) begin
        cmd_code_q <= cfg_data_i;
      end else if (cfg_index_i == rfc_pkg::REG_MIN_LENGTH) begin
        min_len_q <= cfg_data_i;
      end
    end
  end

  assign out_free    = !out_valid_q || out_ready_i;
  assign s1_fire     = s1_valid_q && (!s1_req_q.last || out_free);
  assign in_ready_o  = !s1_valid_q || s1_fire;
  assign s1_valid_d  = (in_valid_i && in_ready_o) ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);
  assign out_valid_d = (s1_fire && s1_req_q.last) ? 1'b1 :
                       (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_req_q.data <= data_byte_i;
      s1_req_q.last <= last_byte_i;
    end
    if (s1_fire && s1_req_q.last) begin
      status_q <= frame_status;
    end
  end

  rfc_frame #(
    .MAX_FRAME(MAX_FRAME)
  ) u_frame (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (s1_fire),
    .req_i         (s1_req_q),
    .command_code_i(cmd_code_q),
    .min_length_i  (min_len_q),
    .status_o      (frame_status)
  );

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;

endmodule

// ===== rtl/rfc_checker.sv =====
// Port-level assertions for the response frame checker and their bind.
`timescale 1ns / 1ps

module rfc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          last_byte_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [1:0]                    status_o
);

  logic [1:0] pending_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 2'(in_valid_i && in_ready_o && last_byte_i)
                             - 2'(out_valid_o && out_ready_i);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("status changed or dropped while stalled");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output back pressure");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 2'd0)
    else $error("status offered without a final byte");

  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q != 2'd3)
    else $error("more than two frames awaiting status");

endmodule

bind response_frame_checker rfc_checker u_rfc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .last_byte_i(last_byte_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .status_o   (status_o)
);

// ===== bench/frame_status_monitor.sv =====
// Scoreboard for the response frame checker: CRC helper package plus the monitor module.
`timescale 1ns / 1ps

package frame_bench_pkg;

  function automatic logic [31:0] crc32_update(input logic [31:0] crc_in, input logic [7:0] d);
    logic [31:0] r;
    r = crc_in;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ d[i]) begin
        r = (r >> 1) ^ rfc_pkg::CRC_POLY;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] header_byte(input int pos);
    return (pos == 2) ? rfc_pkg::SYNC_HI : (pos == 3) ? rfc_pkg::SYNC_LO : 8'h00;
  endfunction

endpackage

module frame_status_monitor (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [1:0] status_i,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [7:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  output int         fail_count_o,
  output int         pending_o
);

  import rfc_pkg::*;
  import frame_bench_pkg::*;

  logic [7:0]  cmd_code;
  logic [7:0]  min_len;
  int          seen;
  int          len_f;
  logic [31:0] crc_run;
  logic [31:0] crc_frame;
  logic [63:0] tail;
  bit          hdr_bad;
  bit          body_bad;
  status_e     status_q[$];
  status_e     want;
  int          errors = 0;

  task automatic report(input string msg);
    $display("monitor: %s at %0t", msg, $time);
    errors++;
  endtask

  task automatic clear_frame();
    seen      = 0;
    len_f     = 0;
    crc_run   = CRC_INIT;
    crc_frame = '0;
    tail      = '0;
    hdr_bad   = 1'b0;
    body_bad  = 1'b0;
  endtask

  function automatic status_e frame_verdict(input bit long_hit);
    if (hdr_bad) return ST_DATA_ERR;
    if (long_hit || seen < BODY_START || seen - BODY_START != len_f ||
        len_f < min_len || len_f < MIN_BODY) return ST_SIZE_ERR;
    if (body_bad) return ST_DATA_ERR;
    if (tail[63:32] != crc_frame) return ST_CRC_ERR;
    if (tail[31:0] != SUFFIX_WORD) return ST_DATA_ERR;
    return ST_OK;
  endfunction

  // Bytes past saturation go uninspected and only force a size error, unless the header was bad.
  task automatic absorb_byte(input logic [7:0] b, input logic last);
    bit long_hit;
    long_hit = 1'b0;
    if (seen >= MAX_FRAME_DEF) begin
      long_hit = 1'b1;
    end else begin
      if (seen < HDR_LEN) begin
        if (b != header_byte(seen)) hdr_bad = 1'b1;
      end else if (seen == CMD_POS) begin
        if (b != cmd_code) hdr_bad = 1'b1;
      end else if (seen < LEN_POS) begin
        if (b != 8'h00) hdr_bad = 1'b1;
      end else if (seen == LEN_POS) begin
        len_f = b;
      end
      if (seen >= BODY_START && seen <= len_f + MIN_BODY - 1 && b != 8'h00) body_bad = 1'b1;
      crc_run = crc32_update(crc_run, b);
      if (seen >= LEN_POS && seen == len_f + MIN_BODY - 1) crc_frame = ~crc_run;
      tail = {tail[55:0], b};
      seen++;
    end
    if (last) begin
      status_q.push_back(frame_verdict(long_hit));
      clear_frame();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_code = CMD_CODE_RST;
      min_len  = MIN_LENGTH_RST;
      clear_frame();
      status_q.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (status_q.size() == 0) begin
          report($sformatf("unexpected status %0d", status_i));
        end else begin
          want = status_q.pop_front();
          if (status_i !== want) begin
            report($sformatf("status %0d, expected %0d", status_i, want));
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_COMMAND_CODE: cmd_code = cfg_data_i;
          REG_MIN_LENGTH:   min_len  = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) absorb_byte(data_byte_i, last_byte_i);
      pending_o <= status_q.size();
    end
    fail_count_o <= errors;
  end

endmodule

// ===== bench/tb_top.sv =====
// Top of the response frame checker bench: clock, reset, stimulus and the final verdict.
`timescale 1ns / 1ps

module tb_top;

  import rfc_pkg::*;
  import frame_bench_pkg::*;

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] data_byte_i = 8'h00;
  logic       last_byte_i = 1'b0;
  logic       out_ready_i = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic [7:0] cfg_index_i = 8'h00;
  logic [7:0] cfg_data_i  = 8'h00;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [1:0] status_o;
  logic       cfg_ready_o;
  int         fails;
  int         pending;

  logic [7:0] frame_q[$];
  logic [7:0] cmd_now = CMD_CODE_RST;
  logic [7:0] min_now = MIN_LENGTH_RST;
  int         bytes_sent = 0;
  int         frames_sent = 0;

  response_frame_checker uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  frame_status_monitor status_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_i     (status_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fails),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  initial begin
    int r;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b0;
        repeat (rand_gap() + 1) @(posedge clk_i);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last, input bit burst);
    int gap;
    gap = burst ? 0 : rand_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  task automatic send_frame();
    bit burst;
    burst = ($urandom_range(0, 4) == 0);
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1, burst);
    frames_sent++;
  endtask

  // Holds the sender until every status has come back and the pipeline has drained.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_COMMAND_CODE) cmd_now = val;
    if (idx == REG_MIN_LENGTH) min_now = val;
  endtask

  task automatic build_frame(input int len);
    logic [31:0] crc;
    frame_q.delete();
    for (int i = 0; i < HDR_LEN; i++) frame_q.push_back(header_byte(i));
    frame_q.push_back(cmd_now);
    repeat (3) frame_q.push_back(8'h00);
    frame_q.push_back(8'(len));
    for (int i = MIN_BODY; i < len; i++) frame_q.push_back(8'h00);
    crc = CRC_INIT;
    foreach (frame_q[i]) crc = crc32_update(crc, frame_q[i]);
    crc = ~crc;
    for (int s = 24; s >= 0; s -= 8) frame_q.push_back(crc[s +: 8]);
    for (int s = 24; s >= 0; s -= 8) frame_q.push_back(SUFFIX_WORD[s +: 8]);
  endtask

  // Half well-formed frames, the rest damaged in one place, cut short, overlong or noise.
  task automatic random_frame();
    int kind;
    int len;
    int n;
    int pos;
    int cut;
    pos = -1;
    kind = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0) len = $urandom_range(41, 239);
    else len = $urandom_range(MIN_BODY, 40);
    if (kind < 50 && min_now > len && min_now <= 239 && $urandom_range(0, 3) == 0) begin
      len = $urandom_range(min_now, (min_now + 16 > 239) ? 239 : min_now + 16);
    end
    if (kind >= 97) begin
      build_frame(239);
      repeat ($urandom_range(1, 40)) frame_q.push_back(8'($urandom_range(0, 255)));
    end else if (kind >= 85) begin
      frame_q.delete();
      repeat ($urandom_range(1, 40)) frame_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      build_frame(len);
      n = frame_q.size();
      if (kind >= 50) begin
        case ($urandom_range(0, 9))
          0: pos = $urandom_range(0, n - 1);
          1: pos = $urandom_range(0, LEN_POS);
          2: pos = BODY_START + $urandom_range(0, len - MIN_BODY);
          3: pos = n - 8 + $urandom_range(0, 3);
          4: pos = n - 4 + $urandom_range(0, 3);
          5: frame_q[LEN_POS] = 8'(len + $urandom_range(1, 255));
          6: begin
            cut = $urandom_range(1, n - 1);
            while (frame_q.size() > cut) void'(frame_q.pop_back());
          end
          7: repeat ($urandom_range(1, 8)) frame_q.push_back(8'($urandom_range(0, 255)));
          8: begin
            build_frame(MIN_BODY);
            cut = $urandom_range(0, MIN_BODY - 1);
            frame_q[LEN_POS] = 8'(cut);
            while (frame_q.size() > cut + BODY_START) void'(frame_q.pop_back());
          end
          default: if (min_now > MIN_BODY) build_frame($urandom_range(MIN_BODY, min_now - 1));
        endcase
        if (pos >= 0 && pos < frame_q.size()) begin
          frame_q[pos] = frame_q[pos] ^ 8'($urandom_range(1, 255));
        end
      end
    end
    send_frame();
  endtask

  initial begin
    int phase_bytes;
    int phase_frames;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    build_frame(MIN_LENGTH_RST);
    send_frame();
    frame_q = '{8'h00};
    send_frame();
    frame_q = '{8'hFF};
    send_frame();

    for (int p = 0; p < 6; p++) begin
      settle();
      case (p)
        0: begin write_reg(REG_COMMAND_CODE, 8'h00); write_reg(REG_MIN_LENGTH, MIN_BODY); end
        1: begin write_reg(REG_COMMAND_CODE, 8'hFF); write_reg(REG_MIN_LENGTH, 8'd239); end
        2: begin
          write_reg(REG_COMMAND_CODE, 8'($urandom_range(0, 255)));
          write_reg(REG_MIN_LENGTH, 8'hFF);
        end
        3: begin
          write_reg(REG_COMMAND_CODE, 8'($urandom_range(0, 255)));
          write_reg(REG_MIN_LENGTH, 8'($urandom_range(9, 30)));
        end
        4: begin
          write_reg(REG_COMMAND_CODE, CMD_CODE_RST);
          write_reg(REG_MIN_LENGTH, MIN_LENGTH_RST);
        end
        default: begin
          write_reg(REG_COMMAND_CODE, 8'($urandom_range(0, 255)));
          write_reg(REG_MIN_LENGTH, 8'($urandom_range(8, 20)));
        end
      endcase
      write_reg(8'($urandom_range(2, 255)), 8'($urandom_range(0, 255)));
      phase_bytes  = bytes_sent;
      phase_frames = frames_sent;
      while (bytes_sent - phase_bytes < 170 || frames_sent - phase_frames < 3) begin
        random_frame();
        if ($urandom_range(0, 19) == 0) settle();
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fails == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
